// ===== rtl/mpq_pkg.sv =====
// ----------------------------------------------------------------------------
// mpq_pkg: shared constants and types for the min priority queue
// Command and status codes, default capacity and the result beat layout.
// ----------------------------------------------------------------------------
package mpq_pkg;

  localparam int unsigned DefCapacity = 64;
  localparam int unsigned KeyW        = 32;
  localparam int unsigned OccW        = 7;

  localparam logic [1:0] CMD_INSERT  = 2'd0;
  localparam logic [1:0] CMD_EXTRACT = 2'd1;
  localparam logic [1:0] CMD_PEEK    = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // One result beat before packing.
  typedef struct packed {
    logic [OccW-1:0] occupancy;
    logic [KeyW-1:0] min_key;
    logic [1:0]      status;
  } result_t;

endpackage

// ===== rtl/mpq_ram.sv =====
// ----------------------------------------------------------------------------
// mpq_ram: generic single-port-write, one-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module mpq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== rtl/mpq_ctrl.sv =====
// ----------------------------------------------------------------------------
// mpq_ctrl: command sequencer for the min priority queue
// Scans the key store for the minimum, one entry a cycle, and on extract
// writes back the last entry over the extracted slot.
// ----------------------------------------------------------------------------
module mpq_ctrl #(
  parameter int unsigned Capacity = mpq_pkg::DefCapacity,
  localparam int unsigned AW = (Capacity > 1) ? $clog2(Capacity) : 1,
  localparam int unsigned CW = $clog2(Capacity + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cmd_valid_i,
  output logic                     cmd_ready_o,
  input  logic [1:0]               cmd_i,
  input  logic [mpq_pkg::KeyW-1:0] key_i,
  output logic                     res_valid_o,
  input  logic                     res_ready_i,
  output mpq_pkg::result_t         res_o,
  output logic                     we_o,
  output logic [AW-1:0]            waddr_o,
  output logic [mpq_pkg::KeyW-1:0] wdata_o,
  output logic [AW-1:0]            raddr_o,
  input  logic [mpq_pkg::KeyW-1:0] rdata_i
);
  import mpq_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_LAST = 3'd2;
  localparam logic [2:0] S_FIX  = 3'd3;

  logic [2:0]      state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic [AW-1:0]   idx_q, idx_d;     // address issued last cycle
  logic [AW-1:0]   best_q, best_d;
  logic [KeyW-1:0] bkey_q, bkey_d;
  logic            first_q, first_d;
  logic            ext_q, ext_d;
  logic            rv_q, rv_d;
  result_t         res_q, res_d;
  logic [CW-1:0]   last_w;
  logic            better;

  assign last_w      = count_q - CW'(1);
  assign better      = first_q || ($signed(rdata_i) < $signed(bkey_q));
  assign cmd_ready_o = (state_q == S_IDLE) && (!rv_q || res_ready_i);
  assign res_valid_o = rv_q;
  assign res_o       = res_q;

  // Sequencer.
  always_comb begin
    state_d = state_q; count_d = count_q; idx_d = idx_q; best_d = best_q;
    bkey_d = bkey_q; first_d = first_q; ext_d = ext_q; res_d = res_q;
    rv_d = rv_q && !res_ready_i;
    we_o = 1'b0; waddr_o = best_q; wdata_o = rdata_i; raddr_o = idx_q;
    case (state_q)
      S_IDLE: begin
        raddr_o = '0;
        if (cmd_valid_i && cmd_ready_o) begin
          res_d.status = ST_OK;
          res_d.min_key = '0;
          res_d.occupancy = OccW'(count_q);
          if (cmd_i == CMD_INSERT) begin
            rv_d = 1'b1;
            if (count_q >= CW'(Capacity)) begin
              res_d.status = ST_FULL;
            end else begin
              we_o = 1'b1; waddr_o = AW'(count_q); wdata_o = key_i;
              count_d = count_q + CW'(1);
              res_d.occupancy = OccW'(count_q + CW'(1));
            end
          end else if (cmd_i == CMD_EXTRACT || cmd_i == CMD_PEEK) begin
            if (count_q == '0) begin
              rv_d = 1'b1; res_d.status = ST_EMPTY;
            end else begin
              ext_d = (cmd_i == CMD_EXTRACT);
              idx_d = '0; first_d = 1'b1; state_d = S_SCAN;
            end
          end else begin
            rv_d = 1'b1;
          end
        end
      end
      S_SCAN: begin
        // rdata holds entry idx_q; compare and issue the next read.
        first_d = 1'b0;
        if (better) begin
          best_d = idx_q; bkey_d = rdata_i;
        end
        if (CW'(idx_q) == last_w) begin
          raddr_o = AW'(last_w);
          state_d = S_LAST;
        end else begin
          raddr_o = idx_q + AW'(1);
          idx_d = idx_q + AW'(1);
        end
      end
      S_LAST: begin
        // rdata holds the last entry.
        res_d.min_key = bkey_q;
        res_d.status = ST_OK;
        if (ext_q) begin
          we_o = 1'b1; waddr_o = best_q; wdata_o = rdata_i;
          count_d = last_w;
          res_d.occupancy = OccW'(last_w);
        end else begin
          res_d.occupancy = OccW'(count_q);
        end
        state_d = S_FIX;
      end
      S_FIX: begin
        rv_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control and payload registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; count_q <= '0; rv_q <= 1'b0;
    end else begin
      state_q <= state_d; count_q <= count_d; rv_q <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d; best_q <= best_d; bkey_q <= bkey_d;
    first_q <= first_d; ext_q <= ext_d; res_q <= res_d;
  end

endmodule

// ===== rtl/min_priority_queue_unit.sv =====
// ----------------------------------------------------------------------------
// min_priority_queue_unit: min priority queue of signed 32-bit keys
// Stream in commands, stream out one status/key/occupancy beat per command.
// ----------------------------------------------------------------------------
// Insert, unknown commands and commands on an empty queue are answered from the idle state.
// Extract and peek scan the key store through its single read port, one
// entry a cycle; extract then writes the last entry into the freed slot.
// One command is in flight at a time, and a finished result must be taken
// before, or while, the next command is accepted.
module min_priority_queue_unit #(
  parameter int unsigned CAPACITY = mpq_pkg::DefCapacity
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // command[1:0], key[33:2], zero fill
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata   // status[1:0], min_key[33:2], occupancy[40:34]
);
  import mpq_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic            we;
  logic [AW-1:0]   waddr, raddr;
  logic [KeyW-1:0] wdata, rdata;
  result_t         res;

  mpq_ram #(.Width(KeyW), .Depth(CAPACITY)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  mpq_ctrl #(.Capacity(CAPACITY)) u_ctrl (
    .clk_i, .rst_ni,
    .cmd_valid_i(s_axis_tvalid), .cmd_ready_o(s_axis_tready),
    .cmd_i(s_axis_tdata[1:0]), .key_i(s_axis_tdata[33:2]),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready), .res_o(res),
    .we_o(we), .waddr_o(waddr), .wdata_o(wdata), .raddr_o(raddr), .rdata_i(rdata)
  );

  assign m_axis_tdata = {7'd0, res.occupancy, res.min_key, res.status};

  // A result beat holds until it is taken.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat dropped or changed while stalled");
  // Empty status always reports zero occupancy.
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.status == ST_EMPTY |-> res.occupancy == '0)
    else $error("empty status with nonzero occupancy");
  // A peek accepted while the last result showed a nonzero occupancy blocks further commands.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tdata[1:0] == CMD_PEEK)
    && res.occupancy != '0 |=> !s_axis_tready)
    else $error("command accepted during a scan");

endmodule
